### hw/rtl/pidc_pkg.sv
// Shared widths, register indexes and sequencer states of the PI duty controller.
package pidc_pkg;

  // Field widths
  localparam int unsigned FB_W    = 12;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned BOUND_W = 24;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned INTEG_W = 25;
  localparam int unsigned ERR_W   = 13;
  localparam int unsigned PROD_W  = 42;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned STEP_W  = 6;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_SETPOINT    = 3'd0,
    CFG_PROP_GAIN   = 3'd1,
    CFG_INTEG_GAIN  = 3'd2,
    CFG_OUT_DIVISOR = 3'd3,
    CFG_INTEG_UPPER = 3'd4,
    CFG_INTEG_LOWER = 3'd5,
    CFG_DUTY_LIMIT  = 3'd6
  } cfg_idx_t;

  // Sequencer states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_INTEG = 8'b0000_0010,
    ST_MULP  = 8'b0000_0100,
    ST_MULI  = 8'b0000_1000,
    ST_ADD   = 8'b0001_0000,
    ST_ABS   = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

endpackage

### hw/rtl/pidc_in_if.sv
// Feedback sample channel: valid, ready and one sample per beat.
interface pidc_in_if;
  logic                          valid;
  logic                          ready;
  logic [pidc_pkg::FB_W-1:0]     feedback_sample;

  modport source (output valid, output feedback_sample, input ready);
  modport sink   (input valid, input feedback_sample, output ready);
endinterface

### hw/rtl/pidc_out_if.sv
// Duty result channel: valid, ready, duty command and saturation flag per beat.
interface pidc_out_if;
  logic                          valid;
  logic                          ready;
  logic [pidc_pkg::DUTY_W-1:0]   duty_out;
  logic                          is_saturated;

  modport source (output valid, output duty_out, output is_saturated, input ready);
  modport sink   (input valid, input duty_out, input is_saturated, output ready);
endinterface

### hw/rtl/pi_duty_controller_antiwindup_top.sv
// PI duty controller with integrator clamp anti-windup, one shared multiplier and divider.
//
//   channel   direction  beat contents
//   in_ch     input      feedback_sample
//   out_ch    output     duty_out, is_saturated
//   cfg_*     input      register write (index, data), no read-back
//
// A sample with a nonzero error passes from acceptance to a ready result through the
// integrator update, two products through one 25x17 multiplier, a sum, a magnitude
// step and a 42-bit quotient from the bit-serial restoring divider. A zero error goes straight to the final step.
// The result beat waits in the output register; a new sample is taken in the meantime
// and its final step waits for that register to empty.
// Synchronous active-low reset clears the state and loads the register defaults.
module pi_duty_controller_antiwindup_top (
  input  logic                         clk,
  input  logic                         rst_n,
  pidc_in_if.sink                      in_ch,
  pidc_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [pidc_pkg::CIDX_W-1:0]  cfg_idx,
  input  logic [pidc_pkg::CFG_W-1:0]   cfg_wdata
);
  import pidc_pkg::*;

  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(PROD_W - 1);

  // Configuration registers
  logic [FB_W-1:0]           setpoint_r;
  logic [GAIN_W-1:0]         prop_gain_r;
  logic [GAIN_W-1:0]         integ_gain_r;
  logic [GAIN_W-1:0]         out_divisor_r;
  logic signed [BOUND_W-1:0] integ_upper_r;
  logic signed [BOUND_W-1:0] integ_lower_r;
  logic [DUTY_W-1:0]         duty_limit_r;

  // Loop state and sequencer
  state_t                    state_r, state_nxt;
  logic signed [INTEG_W-1:0] integ_r;
  logic                      sat_r;
  logic [DUTY_W-1:0]         duty_r;
  logic                      out_valid_r;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  acc_r;
  logic [PROD_W-1:0]         quo_r;
  logic [GAIN_W-1:0]         rem_r;
  logic                      neg_r;
  logic                      hold_r;
  logic [STEP_W-1:0]         step_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r    <= '0;
      prop_gain_r   <= '0;
      integ_gain_r  <= '0;
      out_divisor_r <= GAIN_W'(1);
      integ_upper_r <= {1'b0, {(BOUND_W-1){1'b1}}};
      integ_lower_r <= {1'b1, {(BOUND_W-1){1'b0}}};
      duty_limit_r  <= '1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SETPOINT:    setpoint_r    <= cfg_wdata[FB_W-1:0];
        CFG_PROP_GAIN:   prop_gain_r   <= cfg_wdata[GAIN_W-1:0];
        CFG_INTEG_GAIN:  integ_gain_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_OUT_DIVISOR: out_divisor_r <= cfg_wdata[GAIN_W-1:0];
        CFG_INTEG_UPPER: integ_upper_r <= cfg_wdata[BOUND_W-1:0];
        CFG_INTEG_LOWER: integ_lower_r <= cfg_wdata[BOUND_W-1:0];
        CFG_DUTY_LIMIT:  duty_limit_r  <= cfg_wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  logic in_fire, out_free;
  assign in_ch.ready         = (state_r == ST_IDLE);
  assign in_fire             = in_ch.valid && in_ch.ready;
  assign out_free            = !out_valid_r || out_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.duty_out     = duty_r;
  assign out_ch.is_saturated = sat_r;

  // Shared multiplier: error or integrator times a gain
  logic signed [INTEG_W-1:0] mul_a;
  logic signed [GAIN_W:0]    mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  always_comb begin
    if (state_r == ST_MULP) begin
      mul_a = INTEG_W'(err_r);
      mul_b = $signed({1'b0, prop_gain_r});
    end else begin
      mul_a = integ_r;
      mul_b = $signed({1'b0, integ_gain_r});
    end
  end
  assign mul_p = mul_a * mul_b;

  // Integrator clamp comparisons
  logic signed [INTEG_W-1:0] upper_ext, lower_ext, integ_sum;
  logic                      integ_en;
  assign upper_ext = INTEG_W'(integ_upper_r);
  assign lower_ext = INTEG_W'(integ_lower_r);
  assign integ_sum = integ_r + INTEG_W'(err_r);
  always_comb begin
    if (sat_r)
      integ_en = 1'b0;
    else if (!err_r[ERR_W-1])
      integ_en = (integ_r < upper_ext);
    else
      integ_en = (integ_r > lower_ext);
  end

  // Restoring divider step: one quotient bit per cycle
  logic [GAIN_W-1:0] div_eff;
  logic [GAIN_W:0]   trial;
  logic [GAIN_W+1:0] diff;
  assign div_eff = (out_divisor_r == '0) ? GAIN_W'(1) : out_divisor_r;
  assign trial   = {rem_r, quo_r[PROD_W-1]};
  assign diff    = {1'b0, trial} - {2'b00, div_eff};

  // Final clamp of the quotient
  logic over_limit;
  assign over_limit = (quo_r > PROD_W'(duty_limit_r));

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_INTEG;
      ST_INTEG: state_nxt = (err_r == '0) ? ST_FIN : ST_MULP;
      ST_MULP:  state_nxt = ST_MULI;
      ST_MULI:  state_nxt = ST_ADD;
      ST_ADD:   state_nxt = ST_ABS;
      ST_ABS:   state_nxt = ST_DIV;
      ST_DIV:   if (step_r == DIV_LAST) state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      integ_r     <= '0;
      sat_r       <= 1'b0;
      duty_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && out_free)
        out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready)
        out_valid_r <= 1'b0;
      if (state_r == ST_INTEG && err_r != '0 && integ_en)
        integ_r <= integ_sum;
      // Commit the result (the previous one is kept on a zero error) and present it as the output beat
      if (state_r == ST_FIN && out_free) begin
        if (!hold_r) begin
          if (neg_r && quo_r != '0) begin
            duty_r <= '0;
          end else if (!neg_r && over_limit) begin
            duty_r <= duty_limit_r;
            sat_r  <= 1'b1;
          end else begin
            duty_r <= quo_r[DUTY_W-1:0];
            sat_r  <= 1'b0;
          end
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        err_r <= $signed({1'b0, setpoint_r}) - $signed({1'b0, in_ch.feedback_sample});
      end
      ST_INTEG: begin
        hold_r <= (err_r == '0);
      end
      ST_MULP: begin
        prod_r <= mul_p;
      end
      ST_MULI: begin
        acc_r  <= prod_r;
        prod_r <= mul_p;
      end
      ST_ADD: begin
        acc_r <= acc_r + prod_r;
      end
      ST_ABS: begin
        neg_r  <= acc_r[PROD_W-1];
        quo_r  <= acc_r[PROD_W-1] ? PROD_W'(-acc_r) : PROD_W'(acc_r);
        rem_r  <= '0;
        step_r <= '0;
      end
      ST_DIV: begin
        if (!diff[GAIN_W+1])
          rem_r <= diff[GAIN_W-1:0];
        else
          rem_r <= trial[GAIN_W-1:0];
        quo_r  <= {quo_r[PROD_W-2:0], ~diff[GAIN_W+1]};
        step_r <= step_r + STEP_W'(1);
      end
      ST_FIN: ;
      default: ;
    endcase
  end

endmodule
